[hdl/eight_voice_sample_mixer_assert.svh]
// Assertion macros shared by the mixer checker.
// Needs signals clk and rst_n in the scope of use.
`ifndef EIGHT_VOICE_SAMPLE_MIXER_ASSERT_SVH
`define EIGHT_VOICE_SAMPLE_MIXER_ASSERT_SVH

// same-cycle implication
`define EVSM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mixer assertion failed");

// next-cycle implication
`define EVSM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mixer assertion failed");

`endif

[hdl/evsm_pkg.sv]
// Types and constants of the eight voice sample mixer.
// No dependencies.
package evsm_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_MIX   = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_e;

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_ST_STOP = 14'b00000000000010,
        S_ST_SCAN = 14'b00000000000100,
        S_ST_MV   = 14'b00000000001000,
        S_ST_VOL  = 14'b00000000010000,
        S_ST_L1   = 14'b00000000100000,
        S_ST_L2   = 14'b00000001000000,
        S_ST_LV   = 14'b00000010000000,
        S_MX_RD   = 14'b00000100000000,
        S_MX_WAIT = 14'b00001000000000,
        S_MX_MUL  = 14'b00010000000000,
        S_MX_D1   = 14'b00100000000000,
        S_MX_D2   = 14'b01000000000000,
        S_OUT     = 14'b10000000000000
    } state_t;

    localparam int MUL_A_W = 15;
    localparam int MUL_B_W = 9;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [15:0] HANDLE_BASE = 16'd100;
    localparam logic [7:0]  SILENCE     = 8'd128;
    localparam logic [6:0]  LEVEL_MAX   = 7'd127;
    localparam logic [4:0]  MASTER_RESET = 5'd31;

    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

endpackage

[hdl/evsm_mul.sv]
// Shared registered multiplier of the mixer sequencer.
// Uses evsm_pkg.
module evsm_mul (
    input  logic                        clk,
    input  evsm_pkg::mul_req_t          req,
    output logic [evsm_pkg::MUL_P_W-1:0] prod
);

    logic [evsm_pkg::MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= evsm_pkg::MUL_P_W'(req.a) * evsm_pkg::MUL_P_W'(req.b);
    end

    assign prod = prod_reg;

endmodule

[hdl/evsm_sample_mem.sv]
// Sample memory: one write port, one registered read port.
// No package dependencies.
module evsm_sample_mem #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/eight_voice_sample_mixer.sv]
// Top level of the eight voice sample mixer: sequencer, voice registers, output register.
// Uses evsm_pkg, evsm_mul and evsm_sample_mem.

// One word in gives one word out. The sequencer runs starts and mixes through one
// shared multiplier and is not ready while it works. Loads and no-ops go straight to the
// output, a start scans for a slot (the oldest-voice scan looks at one voice a cycle),
// a mix steps through the voices and multiplies only for active ones (left and right
// level products go through the multiplier one after the other). A finished word sits
// in the output register while the next word is taken. SAMPLE_STORE_DEPTH must be a
// power of two; the store needs no clearing after reset.
module eight_voice_sample_mixer #(
    parameter int VOICE_COUNT        = 8,
    parameter int SAMPLE_STORE_DEPTH = 65536
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // sample_address, sample_byte, sound_id, single_instance, sound_length,
    // volume, separation, step, current_tick, zero pad
    input  logic [119:0] s_tdata,
    // command
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // left_out, right_out, handle, level_clamped, active_voices, zero pad
    output logic [55:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [4:0]   cfg_data
);

    localparam int ADDR_W = $clog2(SAMPLE_STORE_DEPTH);
    localparam int VI_W   = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int CNT_W  = $clog2(VOICE_COUNT + 1);
    localparam int ACC_W  = 18 + VI_W;
    localparam logic [VI_W-1:0] LAST_VOICE = VI_W'(VOICE_COUNT - 1);

    evsm_pkg::state_t state_reg, state_next;

    // latched input word
    logic [15:0] addr_reg;
    logic [7:0]  id_reg;
    logic        single_reg;
    logic [15:0] len_reg;
    logic [7:0]  volume_reg;
    logic [7:0]  sep_reg;
    logic [17:0] step_reg;
    logic [30:0] tick_reg;

    logic [4:0]  master_reg;
    logic [15:0] hcnt_reg;
    logic [15:0] handle_reg;
    logic        clamp_reg;
    logic [VI_W-1:0] vidx_reg;
    logic [VI_W-1:0] oldest_idx_reg;
    logic [VI_W-1:0] slot_reg;
    logic [30:0] oldest_reg;
    logic        ch_reg;
    logic [6:0]  vol_reg;
    logic [6:0]  lvl_l_reg;
    logic [7:0]  smp_reg;
    logic [14:0] y_reg;
    logic [8:0]  q0_reg;
    logic signed [ACC_W-1:0] acc_l_reg, acc_r_reg;

    logic                 out_valid_reg;
    logic [55:0]          out_data_reg;

    // voice state
    logic [VOICE_COUNT-1:0] v_active_reg;
    logic [16:0] v_pos_reg   [VOICE_COUNT];
    logic [16:0] v_end_reg   [VOICE_COUNT];
    logic [17:0] v_rate_reg  [VOICE_COUNT];
    logic [15:0] v_frac_reg  [VOICE_COUNT];
    logic [30:0] v_tick_reg  [VOICE_COUNT];
    logic [7:0]  v_sound_reg [VOICE_COUNT];
    logic [6:0]  v_lvl_l_reg [VOICE_COUNT];
    logic [6:0]  v_lvl_r_reg [VOICE_COUNT];

    evsm_pkg::mul_req_t              mul_req;
    logic [evsm_pkg::MUL_P_W-1:0]    prod;
    logic [7:0]                      mem_rdata;
    logic                            in_acc;
    logic                            out_load;

    logic [VOICE_COUNT-1:0] dup_hit, dup_first;
    logic [8:0]  d_abs;
    logic signed [9:0] lvl_diff;
    logic [6:0]  lvl_clip;
    logic        lvl_bad;
    logic [24:0] recip_t;
    logic [15:0] q0x127, rem;
    logic [15:0] qmag;
    logic signed [ACC_W-1:0] contrib;
    logic [18:0] frac_sum;
    logic [17:0] pos_sum;
    logic [CNT_W-1:0] n_active;
    logic signed [15:0] left_sat, right_sat;

    function automatic logic [7:0] mag_of(input logic [7:0] s);
        return (s >= evsm_pkg::SILENCE) ? (s - evsm_pkg::SILENCE) : (evsm_pkg::SILENCE - s);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(signed'(32767)))
            return 16'sh7fff;
        else if (v < -ACC_W'(signed'(32768)))
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    assign s_tready  = (state_reg == evsm_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign out_load  = (state_reg == evsm_pkg::S_OUT) && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    evsm_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    evsm_sample_mem #(
        .DEPTH  (SAMPLE_STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (in_acc && (s_tuser == evsm_pkg::CMD_LOAD)),
        .waddr (ADDR_W'(s_tdata[15:0])),
        .wdata (s_tdata[23:16]),
        .raddr (ADDR_W'(v_pos_reg[vidx_reg])),
        .rdata (mem_rdata)
    );

    // datapath combinational terms
    always_comb
    begin
        for (int i = 0; i < VOICE_COUNT; i++)
        begin
            dup_hit[i] = v_active_reg[i] && (v_sound_reg[i] == id_reg);
        end
        dup_first = dup_hit & (~dup_hit + VOICE_COUNT'(1));

        d_abs = ch_reg ? (9'd256 - 9'(sep_reg)) : (9'(sep_reg) + 9'd1);

        lvl_diff = signed'({3'b000, vol_reg}) - signed'({2'b00, prod[23:16]});
        lvl_bad  = (lvl_diff < 0) || (lvl_diff > 10'sd127);
        if (lvl_diff < 0)
            lvl_clip = 7'd0;
        else if (lvl_diff > 10'sd127)
            lvl_clip = evsm_pkg::LEVEL_MAX;
        else
            lvl_clip = lvl_diff[6:0];

        // y + y/127, with y/127 by reciprocal and one correction step
        recip_t = (25'(prod[13:0]) << 11) + (25'(prod[13:0]) << 4);
        q0x127  = (16'(q0_reg) << 7) - 16'(q0_reg);
        rem     = 16'(y_reg) - q0x127;
        qmag    = 16'(y_reg) + 16'(q0_reg) + ((rem >= 16'd127) ? 16'd1 : 16'd0);
        contrib = (smp_reg < evsm_pkg::SILENCE) ? -signed'(ACC_W'(qmag))
                                                : signed'(ACC_W'(qmag));

        frac_sum = 19'(v_frac_reg[vidx_reg]) + 19'(v_rate_reg[vidx_reg]);
        pos_sum  = 18'(v_pos_reg[vidx_reg]) + 18'(frac_sum[18:16]);

        n_active = '0;
        for (int i = 0; i < VOICE_COUNT; i++)
        begin
            n_active = n_active + CNT_W'(v_active_reg[i]);
        end
        left_sat  = sat16(acc_l_reg);
        right_sat = sat16(acc_r_reg);
    end

    // multiplier operand select
    always_comb
    begin
        mul_req.a = '0;
        mul_req.b = '0;
        case (state_reg)
            evsm_pkg::S_ST_MV:
            begin
                mul_req.a = 15'(volume_reg);
                mul_req.b = 9'(master_reg);
            end
            evsm_pkg::S_ST_L1:
            begin
                mul_req.a = 15'(vol_reg);
                mul_req.b = d_abs;
            end
            evsm_pkg::S_ST_L2:
            begin
                mul_req.a = prod[14:0];
                mul_req.b = d_abs;
            end
            evsm_pkg::S_MX_WAIT:
            begin
                mul_req.a = 15'(v_lvl_l_reg[vidx_reg]);
                mul_req.b = 9'(mag_of(mem_rdata));
            end
            evsm_pkg::S_MX_MUL:
            begin
                mul_req.a = 15'(v_lvl_r_reg[vidx_reg]);
                mul_req.b = 9'(mag_of(smp_reg));
            end
            default:
            begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            evsm_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    case (s_tuser)
                        evsm_pkg::CMD_START: state_next = evsm_pkg::S_ST_STOP;
                        evsm_pkg::CMD_MIX:   state_next = evsm_pkg::S_MX_RD;
                        default:             state_next = evsm_pkg::S_OUT;
                    endcase
                end
            end
            evsm_pkg::S_ST_STOP: state_next = evsm_pkg::S_ST_SCAN;
            evsm_pkg::S_ST_SCAN:
            begin
                if (!v_active_reg[vidx_reg] || (vidx_reg == LAST_VOICE))
                    state_next = evsm_pkg::S_ST_MV;
            end
            evsm_pkg::S_ST_MV:   state_next = evsm_pkg::S_ST_VOL;
            evsm_pkg::S_ST_VOL:  state_next = evsm_pkg::S_ST_L1;
            evsm_pkg::S_ST_L1:   state_next = evsm_pkg::S_ST_L2;
            evsm_pkg::S_ST_L2:   state_next = evsm_pkg::S_ST_LV;
            evsm_pkg::S_ST_LV:   state_next = ch_reg ? evsm_pkg::S_OUT : evsm_pkg::S_ST_L1;
            evsm_pkg::S_MX_RD:
            begin
                if (v_active_reg[vidx_reg])
                    state_next = evsm_pkg::S_MX_WAIT;
                else if (vidx_reg == LAST_VOICE)
                    state_next = evsm_pkg::S_OUT;
            end
            evsm_pkg::S_MX_WAIT: state_next = evsm_pkg::S_MX_D1;
            evsm_pkg::S_MX_MUL:  state_next = evsm_pkg::S_MX_D1;
            evsm_pkg::S_MX_D1:   state_next = evsm_pkg::S_MX_D2;
            evsm_pkg::S_MX_D2:
            begin
                if (!ch_reg)
                    state_next = evsm_pkg::S_MX_MUL;
                else if (vidx_reg == LAST_VOICE)
                    state_next = evsm_pkg::S_OUT;
                else
                    state_next = evsm_pkg::S_MX_RD;
            end
            evsm_pkg::S_OUT:
            begin
                if (out_load)
                    state_next = evsm_pkg::S_IDLE;
            end
            default: state_next = evsm_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= evsm_pkg::S_IDLE;
            master_reg    <= evsm_pkg::MASTER_RESET;
            hcnt_reg      <= '0;
            v_active_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                master_reg <= cfg_data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                evsm_pkg::S_ST_STOP:
                begin
                    if (single_reg)
                        v_active_reg <= v_active_reg & ~dup_first;
                end
                evsm_pkg::S_ST_LV:
                begin
                    if (ch_reg)
                    begin
                        v_active_reg[slot_reg] <= 1'b1;
                        hcnt_reg <= ((hcnt_reg == '0) ? evsm_pkg::HANDLE_BASE : hcnt_reg)
                                    + 16'd1;
                    end
                end
                evsm_pkg::S_MX_D2:
                begin
                    if (ch_reg && (pos_sum >= 18'(v_end_reg[vidx_reg])))
                        v_active_reg[vidx_reg] <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            evsm_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    addr_reg   <= s_tdata[15:0];
                    id_reg     <= s_tdata[31:24];
                    single_reg <= s_tdata[32];
                    len_reg    <= s_tdata[48:33];
                    volume_reg <= s_tdata[56:49];
                    sep_reg    <= s_tdata[64:57];
                    step_reg   <= s_tdata[82:65];
                    tick_reg   <= s_tdata[113:83];
                    oldest_reg <= s_tdata[113:83];
                    oldest_idx_reg <= '0;
                    vidx_reg   <= '0;
                    ch_reg     <= 1'b0;
                    clamp_reg  <= 1'b0;
                    handle_reg <= '0;
                    acc_l_reg  <= '0;
                    acc_r_reg  <= '0;
                end
            end
            evsm_pkg::S_ST_SCAN:
            begin
                // first free voice wins, else the oldest start tick below now
                if (!v_active_reg[vidx_reg])
                    slot_reg <= vidx_reg;
                else if (v_tick_reg[vidx_reg] < oldest_reg)
                begin
                    oldest_reg     <= v_tick_reg[vidx_reg];
                    oldest_idx_reg <= vidx_reg;
                    slot_reg       <= vidx_reg;
                end
                else
                    slot_reg <= oldest_idx_reg;
                if (vidx_reg != LAST_VOICE)
                    vidx_reg <= vidx_reg + VI_W'(1);
            end
            evsm_pkg::S_ST_VOL:
                vol_reg <= prod[12:6];
            evsm_pkg::S_ST_LV:
            begin
                if (lvl_bad)
                    clamp_reg <= 1'b1;
                if (!ch_reg)
                begin
                    lvl_l_reg <= lvl_clip;
                    ch_reg    <= 1'b1;
                end
                else
                begin
                    v_pos_reg[slot_reg]   <= 17'(addr_reg);
                    v_end_reg[slot_reg]   <= 17'(addr_reg) + 17'(len_reg);
                    v_rate_reg[slot_reg]  <= step_reg;
                    v_frac_reg[slot_reg]  <= '0;
                    v_tick_reg[slot_reg]  <= tick_reg;
                    v_sound_reg[slot_reg] <= id_reg;
                    v_lvl_l_reg[slot_reg] <= lvl_l_reg;
                    v_lvl_r_reg[slot_reg] <= lvl_clip;
                    handle_reg <= (hcnt_reg == '0) ? evsm_pkg::HANDLE_BASE : hcnt_reg;
                end
            end
            evsm_pkg::S_MX_RD:
            begin
                if (!v_active_reg[vidx_reg] && (vidx_reg != LAST_VOICE))
                    vidx_reg <= vidx_reg + VI_W'(1);
            end
            evsm_pkg::S_MX_WAIT:
                smp_reg <= mem_rdata;
            evsm_pkg::S_MX_D1:
            begin
                y_reg  <= {prod[13:0], 1'b0};
                q0_reg <= {1'b0, recip_t[24:17]};
            end
            evsm_pkg::S_MX_D2:
            begin
                if (!ch_reg)
                begin
                    acc_l_reg <= acc_l_reg + contrib;
                    ch_reg    <= 1'b1;
                end
                else
                begin
                    acc_r_reg <= acc_r_reg + contrib;
                    ch_reg    <= 1'b0;
                    v_frac_reg[vidx_reg] <= frac_sum[15:0];
                    v_pos_reg[vidx_reg]  <= pos_sum[16:0];
                    if (vidx_reg != LAST_VOICE)
                        vidx_reg <= vidx_reg + VI_W'(1);
                end
            end
            evsm_pkg::S_OUT:
            begin
                if (out_load)
                begin
                    out_data_reg <= {3'b000, 4'(n_active), clamp_reg, handle_reg,
                                     right_sat, left_sat};
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[hdl/evsm_checker.sv]
// Port-level checker for the eight voice sample mixer, bound to the top level.
// Uses eight_voice_sample_mixer_assert.svh.
`include "eight_voice_sample_mixer_assert.svh"

module evsm_checker #(
    parameter int VOICE_COUNT = 8
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // a stalled output word holds
    `EVSM_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // one word in flight at a time through the sequencer
    `EVSM_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // clamp flag only comes with a start, which always carries a handle
    `EVSM_ASSERT_NOW(a_clamp_has_handle, m_tvalid && m_tdata[48], m_tdata[47:32] != 16'd0)
    // a start word carries no audio
    `EVSM_ASSERT_NOW(a_start_silent, m_tvalid && (|m_tdata[47:32]), m_tdata[31:0] == 32'd0)
    `EVSM_ASSERT_NOW(a_voice_count, m_tvalid, {2'b00, m_tdata[52:49]} <= 6'(VOICE_COUNT))

endmodule

bind eight_voice_sample_mixer evsm_checker #(.VOICE_COUNT(VOICE_COUNT)) u_evsm_checker (.*);

[tb/eight_voice_sample_mixer_test.sv]
// Self-checking testbench for eight_voice_sample_mixer: loads, starts, mixes and no-ops.
// Results are predicted in order and compared field by field. Depends on evsm_pkg.
module eight_voice_sample_mixer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_VOICES  = 8;
    localparam int STORE_DEPTH = 65536;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        evsm_pkg::cmd_e cmd;
        logic [15:0]  addr;
        logic [7:0]   sbyte;
        logic [7:0]   sid;
        logic         single;
        logic [15:0]  len;
        logic [7:0]   vol;
        logic [7:0]   sep;
        logic [17:0]  rate;
        logic [30:0]  tick;
    } mixer_word_t;

    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
        logic [15:0] handle;
        logic        clamped;
        logic [3:0]  active;
    } frame_word_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [55:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [4:0]   cfg_data;

    eight_voice_sample_mixer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // words waiting to be sent, frames waiting to come back
    mixer_word_t pending_words[$];
    frame_word_t expected_frames[$];
    int          mismatches;

    // shadow copy of the mixer state
    logic [7:0]  store_shadow[int];
    logic        v_on[NUM_VOICES];
    logic [16:0] v_pos[NUM_VOICES];
    logic [16:0] v_end[NUM_VOICES];
    logic [17:0] v_rate[NUM_VOICES];
    logic [15:0] v_frac[NUM_VOICES];
    logic [30:0] v_tick[NUM_VOICES];
    logic [7:0]  v_sid[NUM_VOICES];
    int          v_lvl_l[NUM_VOICES];
    int          v_lvl_r[NUM_VOICES];
    logic [15:0] handle_next;
    logic [4:0]  master_vol;
    logic [30:0] game_tick;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pan_level(int v, int d, ref logic clamped);
        int lvl;
        lvl = v - ((v * d * d) / 65536);
        if (lvl < 0)
        begin
            clamped = 1'b1;
            return 0;
        end
        if (lvl > 127)
        begin
            clamped = 1'b1;
            return 127;
        end
        return lvl;
    endfunction

    function automatic int saturate16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic frame_word_t mix_predict(mixer_word_t w);
        frame_word_t r;
        int          lsum, rsum, i, slot, oldest_idx, s, acc, npos, vv, cnt;
        logic [30:0] oldest;
        lsum = 0;
        rsum = 0;
        r.handle = '0;
        r.clamped = 1'b0;
        case (w.cmd)
            evsm_pkg::CMD_LOAD: store_shadow[int'(w.addr)] = w.sbyte;
            evsm_pkg::CMD_START:
            begin
                if (w.single)
                begin
                    for (i = 0; i < NUM_VOICES; i++)
                    begin
                        if (v_on[i] && v_sid[i] == w.sid)
                        begin
                            v_on[i] = 1'b0;
                            break;
                        end
                    end
                end
                oldest = w.tick;
                oldest_idx = 0;
                slot = -1;
                for (i = 0; i < NUM_VOICES; i++)
                begin
                    if (!v_on[i])
                    begin
                        slot = i;
                        break;
                    end
                    if (v_tick[i] < oldest)
                    begin
                        oldest = v_tick[i];
                        oldest_idx = i;
                    end
                end
                if (slot < 0) slot = oldest_idx;
                v_on[slot] = 1'b1;
                v_pos[slot] = {1'b0, w.addr};
                v_end[slot] = {1'b0, w.addr} + 17'(w.len);
                if (handle_next == 16'd0) handle_next = evsm_pkg::HANDLE_BASE;
                r.handle = handle_next;
                handle_next = handle_next + 16'd1;
                v_rate[slot] = w.rate;
                v_frac[slot] = '0;
                v_tick[slot] = w.tick;
                vv = (int'(w.vol) * int'(master_vol)) >> 6;
                v_lvl_l[slot] = pan_level(vv, int'(w.sep) + 1, r.clamped);
                v_lvl_r[slot] = pan_level(vv, int'(w.sep) - 256, r.clamped);
                v_sid[slot] = w.sid;
            end
            evsm_pkg::CMD_MIX:
            begin
                for (i = 0; i < NUM_VOICES; i++)
                begin
                    if (!v_on[i]) continue;
                    s = int'(store_shadow[int'(v_pos[i]) % STORE_DEPTH]);
                    lsum += (v_lvl_l[i] * (s - 128) * 256) / 127;
                    rsum += (v_lvl_r[i] * (s - 128) * 256) / 127;
                    acc = int'(v_frac[i]) + int'(v_rate[i]);
                    npos = int'(v_pos[i]) + (acc >> 16);
                    v_frac[i] = acc[15:0];
                    v_pos[i] = npos[16:0];
                    if (npos >= int'(v_end[i])) v_on[i] = 1'b0;
                end
                lsum = saturate16(lsum);
                rsum = saturate16(rsum);
            end
            default: ;
        endcase
        cnt = 0;
        for (i = 0; i < NUM_VOICES; i++) cnt += int'(v_on[i]);
        r.left = lsum[15:0];
        r.right = rsum[15:0];
        r.active = cnt[3:0];
        return r;
    endfunction

    task automatic queue_word(mixer_word_t w);
        pending_words.push_back(w);
        expected_frames.push_back(mix_predict(w));
    endtask

    function automatic mixer_word_t blank_word(evsm_pkg::cmd_e c);
        mixer_word_t w;
        w.cmd = c;
        w.addr = 16'($urandom);
        w.sbyte = 8'($urandom);
        w.sid = 8'($urandom);
        w.single = 1'($urandom);
        w.len = 16'($urandom);
        w.vol = 8'($urandom);
        w.sep = 8'($urandom);
        w.rate = 18'($urandom);
        w.tick = 31'($urandom);
        return w;
    endfunction

    task automatic load_byte(logic [15:0] a, logic [7:0] b);
        mixer_word_t w;
        w = blank_word(evsm_pkg::CMD_LOAD);
        w.addr = a;
        w.sbyte = b;
        queue_word(w);
    endtask

    task automatic start_sound(logic [15:0] a, logic [15:0] len, logic [7:0] sid,
                               logic single, logic [7:0] vol, logic [7:0] sep,
                               logic [17:0] rate, logic [30:0] tick);
        mixer_word_t w;
        w = blank_word(evsm_pkg::CMD_START);
        w.addr = a;
        w.len = len;
        w.sid = sid;
        w.single = single;
        w.vol = vol;
        w.sep = sep;
        w.rate = rate;
        w.tick = tick;
        queue_word(w);
    endtask

    // every voice about to be read must hit a written byte; fill holes first
    task automatic mix_frame();
        int i;
        for (i = 0; i < NUM_VOICES; i++)
            if (v_on[i] && !store_shadow.exists(int'(v_pos[i]) % STORE_DEPTH))
                load_byte(v_pos[i][15:0], 8'($urandom));
        queue_word(blank_word(evsm_pkg::CMD_MIX));
    endtask

    task automatic random_word();
        int          pick;
        logic [15:0] a, len;
        logic [17:0] rate;
        logic [30:0] tick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            load_byte($urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 255)),
                      8'($urandom));
        else if (pick < 50)
        begin
            a = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
            len = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
            rate = ($urandom_range(0, 5) == 0) ? 18'($urandom) :
                   18'($urandom_range(0, 3 * 65536));
            game_tick = game_tick + 31'($urandom_range(0, 3));
            tick = ($urandom_range(0, 15) == 0) ? 31'($urandom) : game_tick;
            start_sound(a, len, ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                        8'($urandom_range(0, 5)), 1'($urandom), 8'($urandom),
                        8'($urandom), rate, tick);
        end
        else if (pick < 95)
            mix_frame();
        else
            queue_word(blank_word(evsm_pkg::CMD_NOP));
    endtask

    task automatic drain_all();
        wait (pending_words.size() == 0 && expected_frames.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_master(logic [4:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        master_vol = v;
    endtask

    // sender: bursts and gaps, with stretches of back-to-back words
    int burst_left, gap_left, send_mode_cnt;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= evsm_pkg::CMD_NOP;
            burst_left = 0;
            gap_left = 0;
            send_mode_cnt = 0;
        end
        else
        begin
            if (s_tvalid && s_tready) void'(pending_words.pop_front());
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_words[0].cmd;
                    s_tdata  <= {6'b0, pending_words[0].tick, pending_words[0].rate,
                                 pending_words[0].sep, pending_words[0].vol,
                                 pending_words[0].len, pending_words[0].single,
                                 pending_words[0].sid, pending_words[0].sbyte,
                                 pending_words[0].addr};
                    send_mode_cnt++;
                    if (burst_left > 0) burst_left--;
                    else if ((send_mode_cnt / 150) % 3 != 2)
                    begin
                        burst_left = $urandom_range(0, 8);
                        gap_left = $urandom_range(1, 30);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern, with stretches of always ready
    int stall_left, rx_cnt;
    always @(posedge clk or negedge rst_n)
    begin
        frame_word_t got, want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
            rx_cnt = 0;
        end
        else
        begin
            rx_cnt++;
            if (m_tvalid && m_tready)
            begin
                got.left    = m_tdata[15:0];
                got.right   = m_tdata[31:16];
                got.handle  = m_tdata[47:32];
                got.clamped = m_tdata[48];
                got.active  = m_tdata[52:49];
                if (expected_frames.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: %h", m_tdata);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (got.left !== want.left || got.right !== want.right ||
                        got.handle !== want.handle || got.clamped !== want.clamped ||
                        got.active !== want.active)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp L %0d R %0d H %0d C %0d A %0d,",
                                     $signed(want.left), $signed(want.right), want.handle,
                                     want.clamped, want.active,
                                     " got L %0d R %0d H %0d C %0d A %0d",
                                     $signed(got.left), $signed(got.right), got.handle,
                                     got.clamped, got.active);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ((rx_cnt / 2000) % 2 == 0 && $urandom_range(0, 4) == 0)
                    stall_left = $urandom_range(1, 40);
            end
        end
    end

    int cycle_cnt;
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("eight_voice_sample_mixer_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        int i, n;
        mismatches = 0;
        cycle_cnt = 0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        for (i = 0; i < NUM_VOICES; i++)
        begin
            v_on[i] = 1'b0;
            v_pos[i] = '0;
            v_end[i] = '0;
            v_rate[i] = '0;
            v_frac[i] = '0;
            v_tick[i] = '0;
            v_sid[i] = '0;
            v_lvl_l[i] = 0;
            v_lvl_r[i] = 0;
        end
        handle_next = '0;
        master_vol = evsm_pkg::MASTER_RESET;
        game_tick = 31'd10;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_master(5'd31);
        // directed: extreme bytes, wrap of the store, pan extremes, zero length and step,
        // duplicate stop, all voices busy with and without an older voice, no-op
        load_byte(16'h0000, 8'h00);
        load_byte(16'hffff, 8'hff);
        load_byte(16'h0001, 8'h80);
        load_byte(16'h0002, 8'hff);
        start_sound(16'hffff, 16'd3, 8'd1, 1'b0, 8'd255, 8'd0, 18'h10000, 31'd5);
        start_sound(16'h0000, 16'd0, 8'd2, 1'b0, 8'd255, 8'd255, 18'h3ffff, 31'd5);
        start_sound(16'h0002, 16'd1, 8'd3, 1'b0, 8'd255, 8'd128, 18'd0, 31'd5);
        start_sound(16'h0001, 16'd2, 8'd1, 1'b1, 8'd0, 8'd64, 18'h08000, 31'd6);
        mix_frame();
        mix_frame();
        for (i = 0; i < 9; i++)
            start_sound(16'hffff, 16'hffff, 8'hff, 1'b0, 8'd255, 8'd0, 18'd0, 31'd5);
        start_sound(16'h0000, 16'd5, 8'd7, 1'b0, 8'd200, 8'd200, 18'h10000, 31'h7fffffff);
        mix_frame();
        queue_word(blank_word(evsm_pkg::CMD_NOP));
        mix_frame();
        drain_all();

        for (n = 0; n < 6; n++)
        begin
            case (n)
                0: write_master(5'd0);
                1: write_master(5'd31);
                2: write_master(5'd1);
                default: write_master(5'($urandom_range(0, 31)));
            endcase
            for (i = 0; i < 100; i++) random_word();
            drain_all();
        end

        if (mismatches == 0)
            $display("eight_voice_sample_mixer_test: done, clean");
        else
            $display("eight_voice_sample_mixer_test: done, errors");
        $finish;
    end
endmodule

[eight_voice_sample_mixer.f]
+incdir+hdl
hdl/evsm_pkg.sv
hdl/evsm_mul.sv
hdl/evsm_sample_mem.sv
hdl/eight_voice_sample_mixer.sv
hdl/evsm_checker.sv
tb/eight_voice_sample_mixer_test.sv
